[hdl/dmm_pkg.sv]
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types, constants and helpers for the dense matrix multiply core.
// ----------------------------------------------------------------------------
package dmm_pkg;

    // Store and element geometry.
    localparam int unsigned MAX_DIM    = 64;
    localparam int unsigned IDX_WIDTH  = $clog2(MAX_DIM);
    localparam int unsigned DIM_WIDTH  = IDX_WIDTH + 1;
    localparam int unsigned ADDR_WIDTH = 2 * IDX_WIDTH;
    localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned DATA_WIDTH = 16;
    localparam int unsigned PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int unsigned ACC_WIDTH  = 40;

    // Stream word layouts; the opcode travels beside the data word.
    localparam int unsigned OPCODE_WIDTH = 2;
    localparam int unsigned IN_BITS      = 2 * IDX_WIDTH + DATA_WIDTH;
    localparam int unsigned IN_WIDTH     = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_BITS     = 2 * IDX_WIDTH + ACC_WIDTH;
    localparam int unsigned OUT_WIDTH    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 7;

    // Opcodes of an input word.
    localparam logic [OPCODE_WIDTH-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OPCODE_WIDTH-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OPCODE_WIDTH-1:0] OP_ROW     = 2'd2;

    // Register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROWS_M  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INNER_N = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLS_K  = 2'd2;

    localparam logic [DIM_WIDTH-1:0] DIM_MAX = DIM_WIDTH'(MAX_DIM);

    // Current matrix sizes.
    typedef struct packed {
        logic [DIM_WIDTH-1:0] rows_m;
        logic [DIM_WIDTH-1:0] inner_n;
        logic [DIM_WIDTH-1:0] cols_k;
    } cfg_t;

    // Sequencer to MAC control.
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

    // MAC status back to the sequencer.
    typedef struct packed {
        logic busy;
    } mac_status_t;

    // Sizes above the store dimension saturate to it.
    function automatic logic [DIM_WIDTH-1:0] clamp_dim(input logic [CFG_DATA_WIDTH-1:0] v);
        logic [DIM_WIDTH-1:0] d;
        d = DIM_WIDTH'(v);
        if (d > DIM_MAX)
        begin
            d = DIM_MAX;
        end
        return d;
    endfunction

endpackage

[hdl/dmm_ram.sv]
// ----------------------------------------------------------------------------
// dmm_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module dmm_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/dmm_mac.sv]
// ----------------------------------------------------------------------------
// dmm_mac
// Registered multiplier followed by an exact wrapping accumulator.
// ----------------------------------------------------------------------------
module dmm_mac (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  dmm_pkg::mac_ctrl_t                       ctrl,
    input  logic signed [dmm_pkg::DATA_WIDTH-1:0]    a_data,
    input  logic signed [dmm_pkg::DATA_WIDTH-1:0]    b_data,
    output dmm_pkg::mac_status_t                     status,
    output logic        [dmm_pkg::ACC_WIDTH-1:0]     acc
);
    import dmm_pkg::*;

    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic                         prod_valid_reg;
    logic [ACC_WIDTH-1:0]         acc_reg;
    logic [ACC_WIDTH-1:0]         acc_next;

    // Product valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.valid;
        end
    end

    // Multiplier stage.
    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            prod_reg <= a_data * b_data;
        end
    end

    // Accumulate the sign-extended product, wrapping at the accumulator width.
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_WIDTH'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign status.busy = prod_valid_reg;
    assign acc         = acc_reg;

endmodule

[hdl/dmm_seq.sv]
// ----------------------------------------------------------------------------
// dmm_seq
// Row sequencer: walks the columns and the summed index of one row of C,
// drives the store reads and the MAC, and holds the output word register.
// ----------------------------------------------------------------------------
module dmm_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dmm_pkg::cfg_t                         cfg,
    input  logic                                  in_accept,
    input  logic [dmm_pkg::OPCODE_WIDTH-1:0]      in_opcode,
    input  logic [dmm_pkg::IDX_WIDTH-1:0]         in_row,
    output logic                                  ready,
    output logic                                  rd_en,
    output logic [dmm_pkg::ADDR_WIDTH-1:0]        a_raddr,
    output logic [dmm_pkg::ADDR_WIDTH-1:0]        b_raddr,
    output dmm_pkg::mac_ctrl_t                    mac_ctrl,
    input  dmm_pkg::mac_status_t                  mac_status,
    input  logic [dmm_pkg::ACC_WIDTH-1:0]         acc,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [dmm_pkg::OUT_WIDTH-1:0]         m_tdata,
    output logic                                  m_tlast
);
    import dmm_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [IDX_WIDTH-1:0] row_reg, row_next;
    logic [IDX_WIDTH-1:0] col_reg, col_next;
    logic [IDX_WIDTH-1:0] p_reg, p_next;
    logic                 rd_valid_reg;
    logic                 issue;
    logic                 clear;
    logic                 start_row;
    logic                 last_p;
    logic                 last_col;
    logic                 emit;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_WIDTH-1:0] out_row_reg;
    logic [IDX_WIDTH-1:0] out_col_reg;
    logic [ACC_WIDTH-1:0] out_sum_reg;
    logic                 out_last_reg;

    assign start_row = in_accept && (in_opcode == OP_ROW) &&
                       ({1'b0, in_row} < cfg.rows_m) && (cfg.cols_k != '0);
    assign last_p    = (DIM_WIDTH'(p_reg) + DIM_WIDTH'(1)) == cfg.inner_n;
    assign last_col  = (DIM_WIDTH'(col_reg) + DIM_WIDTH'(1)) == cfg.cols_k;
    assign emit      = (state_reg == S_DRAIN) && !rd_valid_reg && !mac_status.busy &&
                       (!out_valid_reg || m_tready);
    assign issue     = (state_reg == S_ISSUE);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        p_next     = p_reg;
        clear      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start_row)
                begin
                    row_next   = in_row;
                    col_next   = '0;
                    p_next     = '0;
                    clear      = 1'b1;
                    state_next = (cfg.inner_n == '0) ? S_DRAIN : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                p_next = p_reg + IDX_WIDTH'(1);
                if (last_p)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (emit)
                begin
                    if (last_col)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + IDX_WIDTH'(1);
                        p_next     = '0;
                        clear      = 1'b1;
                        state_next = (cfg.inner_n == '0) ? S_DRAIN : S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_valid_reg <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            p_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            row_reg      <= row_next;
            col_reg      <= col_next;
            p_reg        <= p_next;
        end
    end

    // Store reads: A walks along the row, B down the column.
    assign rd_en          = issue;
    assign a_raddr        = {row_reg, p_reg};
    assign b_raddr        = {p_reg, col_reg};
    assign mac_ctrl.valid = rd_valid_reg;
    assign mac_ctrl.clear = clear;

    // Output word register.
    assign out_valid_next = emit || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            out_sum_reg  <= acc;
            out_last_reg <= last_col;
        end
    end

    assign ready    = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_WIDTH'({out_sum_reg, out_col_reg, out_row_reg});
    assign m_tlast  = out_last_reg;

endmodule

[hdl/dense_matrix_multiply_core.sv]
// Element writes leave the core idle, so it stays ready for further input words.
// A row request walks the cols_k columns in turn, issuing inner_n store reads per
// column; an output word that is not taken stalls the row.
// The single shared multiplier and the one-read-per-cycle stores serialise the work,
// and no new input word is taken until the row is done.
// Reset clears control and sets the sizes to 64; store contents are undefined.
// ----------------------------------------------------------------------------
// dense_matrix_multiply_core
// Computes one row of C = A x B per request from two on-chip element stores.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [dmm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [dmm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    // Input stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // row_index[5:0], col_index[11:6], element_value[27:12], zero pad
    input  logic [dmm_pkg::IN_WIDTH-1:0]          s_tdata,
    // opcode[1:0]
    input  logic [dmm_pkg::OPCODE_WIDTH-1:0]      s_tuser,
    // Output stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_row[5:0], out_col[11:6], product_sum[51:12], zero pad
    output logic [dmm_pkg::OUT_WIDTH-1:0]         m_tdata,
    output logic                                  m_tlast
);
    import dmm_pkg::*;

    cfg_t                          cfg_reg;
    logic                          in_accept;
    logic [OPCODE_WIDTH-1:0]       in_opcode;
    logic [IDX_WIDTH-1:0]          in_row;
    logic [IDX_WIDTH-1:0]          in_col;
    logic [DATA_WIDTH-1:0]         in_value;
    logic [ADDR_WIDTH-1:0]         waddr;
    logic                          a_we;
    logic                          b_we;
    logic                          rd_en;
    logic [ADDR_WIDTH-1:0]         a_raddr;
    logic [ADDR_WIDTH-1:0]         b_raddr;
    logic [DATA_WIDTH-1:0]         a_rdata;
    logic [DATA_WIDTH-1:0]         b_rdata;
    mac_ctrl_t                     mac_ctrl;
    mac_status_t                   mac_status;
    logic [ACC_WIDTH-1:0]          acc;

    // Size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows_m  <= DIM_MAX;
            cfg_reg.inner_n <= DIM_MAX;
            cfg_reg.cols_k  <= DIM_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_M:  cfg_reg.rows_m  <= clamp_dim(cfg_data);
                REG_INNER_N: cfg_reg.inner_n <= clamp_dim(cfg_data);
                REG_COLS_K:  cfg_reg.cols_k  <= clamp_dim(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // Input word fields.
    assign in_accept = s_tvalid && s_tready;
    assign in_opcode = s_tuser;
    assign in_row    = s_tdata[IDX_WIDTH-1:0];
    assign in_col    = s_tdata[IDX_WIDTH +: IDX_WIDTH];
    assign in_value  = s_tdata[2 * IDX_WIDTH +: DATA_WIDTH];

    // Element writes go straight into the stores.
    assign waddr = {in_row, in_col};
    assign a_we  = in_accept && (in_opcode == OP_WRITE_A);
    assign b_we  = in_accept && (in_opcode == OP_WRITE_B);

    dmm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (in_value),
        .re    (rd_en),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    dmm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (in_value),
        .re    (rd_en),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Multiply-accumulate datapath.
    dmm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .status (mac_status),
        .acc    (acc)
    );

    // Row sequencer and output register.
    dmm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_accept  (in_accept),
        .in_opcode  (in_opcode),
        .in_row     (in_row),
        .ready      (s_tready),
        .rd_en      (rd_en),
        .a_raddr    (a_raddr),
        .b_raddr    (b_raddr),
        .mac_ctrl   (mac_ctrl),
        .mac_status (mac_status),
        .acc        (acc),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
